[rtl/fpr_pkg.sv]
// Shared types, constants and the CRC step function for the framed packet receiver.
package fpr_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int unsigned MEM_AW      = PAY_AW + 1;
  localparam int unsigned FC_W        = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned STATUS_W    = 3;

  localparam logic [15:0]     CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]     CRC_POLY  = 16'hA001;
  localparam logic [FC_W-1:0] HDR_LAST  = FC_W'(3);
  localparam logic [FC_W-1:0] PAY_LIMIT = FC_W'(MAX_PAYLOAD);

  localparam logic [CFG_IDX_W-1:0] CFG_SOF_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOF_TWO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

  localparam logic [7:0]      SOF_ONE_RST  = 8'hA5;
  localparam logic [7:0]      SOF_TWO_RST  = 8'h5A;
  localparam logic [7:0]      VERSION_RST  = 8'h01;
  localparam logic [FC_W-1:0] MAX_LEN_RST  = 7'd64;
  localparam logic [15:0]     TIMEOUT_RST  = 16'd100;

  typedef enum logic [2:0] {
    PH_SOF1,
    PH_SOF2,
    PH_HDR,
    PH_PAY,
    PH_CRCL,
    PH_CRCH
  } fpr_phase_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_EMIT
  } fpr_bstate_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_LEN     = 3'd1,
    ST_CRC     = 3'd2,
    ST_VER     = 3'd3,
    ST_TIMEOUT = 3'd4
  } fpr_status_t;

  typedef struct packed {
    fpr_status_t status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_len;
    logic [15:0] detail;
    logic        has_payload;
    logic        bank;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } pay_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/fpr_channels.sv]
// Handshake channel interfaces for received items and result transactions.
interface fpr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface fpr_out_if;
  logic                         valid;
  logic                         ready;
  logic [fpr_pkg::STATUS_W-1:0] status;
  logic [7:0]                   frame_type;
  logic [7:0]                   frame_seq;
  logic [7:0]                   frame_len;
  logic [15:0]                  detail;
  logic [7:0]                   payload_byte;
  logic [fpr_pkg::PAY_AW-1:0]   byte_index;
  logic                         has_payload;
  logic                         last;

  modport source (output valid, output status, output frame_type, output frame_seq,
                  output frame_len, output detail, output payload_byte,
                  output byte_index, output has_payload, output last, input ready);
  modport sink   (input valid, input status, input frame_type, input frame_seq,
                  input frame_len, input detail, input payload_byte,
                  input byte_index, input has_payload, input last, output ready);
endinterface

[rtl/framed_packet_receiver_top.sv]
// Framed packet receiver: start-byte hunt, header, payload, CRC-16 check and results.
//
// in_ch takes one transaction per item: a received byte (mode 0) or a time tick
// (mode 1). out_ch gives result transactions: one per payload byte of a good
// frame, or one status transaction, with last marking the final one.
// cfg_we/cfg_index/cfg_data write the five registers; write only while idle.
// in_ch takes one item per cycle while in_ch.ready is high. The parser queues a
// job at the end of a frame or on an error; the emitter takes it from the queue,
// and each payload result waits for the registered read of the payload buffer
// before it is offered. Two payload banks and a two-entry job queue let the
// parser take the next frame while results drain; in_ch.ready drops only when
// both banks still await readout or the queue is full.
// Reset (rst_n low, synchronous) restores register defaults, returns the parser
// to the start-byte hunt and empties the queue; no clearing pass is needed.
// A stalled out_ch holds its transaction steady; the parser keeps running until
// the queue or the banks fill.
module framed_packet_receiver_top (
  input  logic                               clk,
  input  logic                               rst_n,
  fpr_in_if.sink                             in_ch,
  fpr_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fpr_pkg::*;

  job_t       push_job;
  job_t       head;
  logic       job_push;
  logic       job_pop;
  fifo_stat_t fifo_stat;
  pay_wr_t    pay_wr;
  bank_rel_t  bank_rel;

  fpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (push_job),
    .job_push  (job_push),
    .fifo_stat (fifo_stat),
    .pay_wr    (pay_wr),
    .bank_rel  (bank_rel)
  );

  fpr_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  fpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (job_pop),
    .bank_rel  (bank_rel),
    .pay_wr    (pay_wr),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && fifo_stat.full))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_pop && fifo_stat.empty))
    else $error("job popped from empty queue");

  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (pay_wr.en && bank_rel.en) |-> (pay_wr.addr[MEM_AW-1] != bank_rel.bank))
    else $error("payload write into bank under readout");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    pay_wr.en |-> (in_ch.valid && in_ch.ready && !in_ch.mode))
    else $error("payload write without an accepted byte");
`endif

endmodule

[rtl/fpr_front.sv]
// Frame parser: hunts start bytes, reads header and payload, checks CRC, queues jobs.
module fpr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  fpr_in_if.sink                              in_ch,
  input  logic                                cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output fpr_pkg::job_t                       job,
  output logic                                job_push,
  input  fpr_pkg::fifo_stat_t                 fifo_stat,
  output fpr_pkg::pay_wr_t                    pay_wr,
  input  fpr_pkg::bank_rel_t                  bank_rel
);
  import fpr_pkg::*;

  fpr_phase_t      phase_r, phase_nxt;
  logic [7:0]      hdr_version_r, hdr_version_nxt;
  logic [7:0]      hdr_type_r, hdr_type_nxt;
  logic [7:0]      hdr_seq_r, hdr_seq_nxt;
  logic [7:0]      hdr_len_r, hdr_len_nxt;
  logic [FC_W-1:0] field_count_r, field_count_nxt;
  logic [7:0]      crc_low_r, crc_low_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     idle_r, idle_nxt;
  logic            wr_bank_r, wr_bank_nxt;
  logic [1:0]      busy_r, busy_nxt;

  logic [7:0]      sof_one_r, sof_two_r, version_r;
  logic [FC_W-1:0] max_len_r;
  logic [15:0]     timeout_r;

  logic            accept;
  logic [7:0]      b;
  logic [15:0]     idle_inc;
  logic            timeout_hit;
  logic [15:0]     crc_upd;
  logic [FC_W-1:0] limit;
  logic            len_bad;
  logic [15:0]     rx_crc;
  logic [FC_W-1:0] fc_inc;
  logic            restart;

  assign in_ch.ready = !fifo_stat.full && !busy_r[wr_bank_r];
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign idle_inc    = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign timeout_hit = idle_inc >= timeout_r;
  assign crc_upd     = crc_feed(crc_r, b);
  assign limit       = (max_len_r < PAY_LIMIT) ? max_len_r : PAY_LIMIT;
  assign len_bad     = b > {1'b0, limit};
  assign rx_crc      = {b, crc_low_r};
  assign fc_inc      = field_count_r + FC_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_ch.mode) begin
        if (phase_r != PH_SOF1 && timeout_hit) begin
          phase_nxt = PH_SOF1;
        end
      end else begin
        unique case (phase_r)
          PH_SOF1: begin
            if (b == sof_one_r) phase_nxt = PH_SOF2;
          end
          PH_SOF2: begin
            if (b == sof_two_r) phase_nxt = PH_HDR;
            else if (b != sof_one_r) phase_nxt = PH_SOF1;
          end
          PH_HDR: begin
            if (field_count_r == HDR_LAST) begin
              if (len_bad) phase_nxt = PH_SOF1;
              else if (b == 8'd0) phase_nxt = PH_CRCL;
              else phase_nxt = PH_PAY;
            end
          end
          PH_PAY: begin
            if ({1'b0, fc_inc} >= hdr_len_r) phase_nxt = PH_CRCL;
          end
          PH_CRCL: phase_nxt = PH_CRCH;
          PH_CRCH: phase_nxt = PH_SOF1;
          default: phase_nxt = PH_SOF1;
        endcase
      end
    end
  end

  always_comb begin
    hdr_version_nxt = hdr_version_r;
    hdr_type_nxt    = hdr_type_r;
    hdr_seq_nxt     = hdr_seq_r;
    hdr_len_nxt     = hdr_len_r;
    field_count_nxt = field_count_r;
    crc_low_nxt     = crc_low_r;
    crc_nxt         = crc_r;
    idle_nxt        = idle_r;
    wr_bank_nxt     = wr_bank_r;
    busy_nxt        = busy_r;
    restart         = 1'b0;
    job_push        = 1'b0;
    pay_wr          = '0;
    job             = '0;
    job.status      = ST_OK;
    job.frame_type  = hdr_type_r;
    job.frame_seq   = hdr_seq_r;
    job.frame_len   = hdr_len_r;

    if (bank_rel.en) busy_nxt[bank_rel.bank] = 1'b0;

    if (accept) begin
      if (in_ch.mode) begin
        if (phase_r != PH_SOF1) begin
          idle_nxt = idle_inc;
          if (timeout_hit) begin
            job_push   = 1'b1;
            job.status = ST_TIMEOUT;
            restart    = 1'b1;
          end
        end
      end else begin
        idle_nxt = 16'd0;
        unique case (phase_r)
          PH_SOF1: begin
            if (b == sof_one_r) begin
              hdr_version_nxt = 8'd0;
              hdr_type_nxt    = 8'd0;
              hdr_seq_nxt     = 8'd0;
              hdr_len_nxt     = 8'd0;
              field_count_nxt = '0;
            end
          end
          PH_SOF2: begin
            if (b == sof_two_r) begin
              hdr_version_nxt = 8'd0;
              hdr_type_nxt    = 8'd0;
              hdr_seq_nxt     = 8'd0;
              hdr_len_nxt     = 8'd0;
              field_count_nxt = '0;
              crc_nxt         = CRC_INIT;
            end else if (b != sof_one_r) begin
              restart = 1'b1;
            end
          end
          PH_HDR: begin
            crc_nxt         = crc_upd;
            field_count_nxt = fc_inc;
            case (field_count_r[1:0])
              2'd0:    hdr_version_nxt = b;
              2'd1:    hdr_type_nxt    = b;
              2'd2:    hdr_seq_nxt     = b;
              default: hdr_len_nxt     = b;
            endcase
            if (field_count_r == HDR_LAST) begin
              field_count_nxt = '0;
              if (len_bad) begin
                job_push      = 1'b1;
                job.status    = ST_LEN;
                job.frame_len = b;
                job.detail    = {8'd0, b};
                restart       = 1'b1;
              end
            end
          end
          PH_PAY: begin
            crc_nxt         = crc_upd;
            field_count_nxt = fc_inc;
            pay_wr.en       = 1'b1;
            pay_wr.addr     = {wr_bank_r, field_count_r[PAY_AW-1:0]};
            pay_wr.data     = b;
          end
          PH_CRCL: crc_low_nxt = b;
          PH_CRCH: begin
            job_push = 1'b1;
            restart  = 1'b1;
            if (rx_crc != crc_r) begin
              job.status = ST_CRC;
              job.detail = rx_crc;
            end else if (hdr_version_r != version_r) begin
              job.status = ST_VER;
              job.detail = {8'd0, hdr_version_r};
            end else if (hdr_len_r != 8'd0) begin
              job.has_payload      = 1'b1;
              job.bank             = wr_bank_r;
              wr_bank_nxt          = !wr_bank_r;
              busy_nxt[wr_bank_r]  = 1'b1;
            end
          end
          default: restart = 1'b1;
        endcase
      end
    end

    if (restart) begin
      hdr_version_nxt = 8'd0;
      hdr_type_nxt    = 8'd0;
      hdr_seq_nxt     = 8'd0;
      hdr_len_nxt     = 8'd0;
      field_count_nxt = '0;
      crc_low_nxt     = 8'd0;
      crc_nxt         = CRC_INIT;
      idle_nxt        = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SOF1;
      hdr_version_r <= 8'd0;
      hdr_type_r    <= 8'd0;
      hdr_seq_r     <= 8'd0;
      hdr_len_r     <= 8'd0;
      field_count_r <= '0;
      crc_low_r     <= 8'd0;
      crc_r         <= CRC_INIT;
      idle_r        <= 16'd0;
      wr_bank_r     <= 1'b0;
      busy_r        <= 2'b00;
    end else begin
      phase_r       <= phase_nxt;
      hdr_version_r <= hdr_version_nxt;
      hdr_type_r    <= hdr_type_nxt;
      hdr_seq_r     <= hdr_seq_nxt;
      hdr_len_r     <= hdr_len_nxt;
      field_count_r <= field_count_nxt;
      crc_low_r     <= crc_low_nxt;
      crc_r         <= crc_nxt;
      idle_r        <= idle_nxt;
      wr_bank_r     <= wr_bank_nxt;
      busy_r        <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_one_r <= SOF_ONE_RST;
      sof_two_r <= SOF_TWO_RST;
      version_r <= VERSION_RST;
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOF_ONE: sof_one_r <= cfg_data[7:0];
        CFG_SOF_TWO: sof_two_r <= cfg_data[7:0];
        CFG_VERSION: version_r <= cfg_data[7:0];
        CFG_MAX_LEN: max_len_r <= cfg_data[FC_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/fpr_job_fifo.sv]
// Two-entry job queue between the parser and the result emitter.
module fpr_job_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fpr_pkg::job_t       push_job,
  input  logic                pop,
  output fpr_pkg::job_t       head,
  output fpr_pkg::fifo_stat_t stat
);
  import fpr_pkg::*;

  job_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head       = q_r[rd_ptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_job;
  end

endmodule

[rtl/fpr_back.sv]
// Result emitter: holds the two payload banks and sends one transaction per result.
module fpr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fpr_pkg::job_t       head,
  input  fpr_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  output fpr_pkg::bank_rel_t  bank_rel,
  input  fpr_pkg::pay_wr_t    pay_wr,
  fpr_out_if.source           out_ch
);
  import fpr_pkg::*;

  fpr_bstate_t       state_r, state_nxt;
  logic [PAY_AW-1:0] idx_r, idx_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [2**MEM_AW];
  logic              last_item;
  logic              done;

  assign last_item = (8'(idx_r) + 8'd1) == head.frame_len;
  assign done      = !head.has_payload || last_item;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (!fifo_stat.empty) state_nxt = head.has_payload ? BS_READ : BS_EMIT;
      end
      BS_READ: state_nxt = BS_EMIT;
      BS_EMIT: begin
        if (out_ch.ready) state_nxt = done ? BS_IDLE : BS_READ;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    out_ch.valid        = state_r == BS_EMIT;
    out_ch.status       = head.status;
    out_ch.frame_type   = head.frame_type;
    out_ch.frame_seq    = head.frame_seq;
    out_ch.frame_len    = head.frame_len;
    out_ch.detail       = head.detail;
    out_ch.payload_byte = head.has_payload ? rd_data_r : 8'd0;
    out_ch.byte_index   = head.has_payload ? idx_r : '0;
    out_ch.has_payload  = head.has_payload;
    out_ch.last         = done;
    pop                 = out_ch.valid && out_ch.ready && done;
    bank_rel.en         = pop && head.has_payload;
    bank_rel.bank       = head.bank;
    idx_nxt             = idx_r;
    if (out_ch.valid && out_ch.ready) idx_nxt = done ? '0 : idx_r + PAY_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_wr.en) mem[pay_wr.addr] <= pay_wr.data;
  end

  always_ff @(posedge clk) begin
    if (state_r == BS_READ) rd_data_r <= mem[{head.bank, idx_r}];
  end

endmodule

[dv/tb_framed_packet_receiver_top.sv]
// Self-checking testbench for the framed packet receiver: frame traffic, tick timeouts, checks.
`timescale 1ns / 100ps

module tb_framed_packet_receiver_top;
  import fpr_pkg::*;

  localparam int HDR_BYTES   = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } link_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          frame_type;
    logic [7:0]          frame_seq;
    logic [7:0]          frame_len;
    logic [15:0]         detail;
    logic [7:0]          payload_byte;
    logic [PAY_AW-1:0]   byte_index;
    logic                has_payload;
    logic                last;
  } frame_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpr_in_if  in_ch ();
  fpr_out_if out_ch ();

  framed_packet_receiver_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies
  logic [7:0]      sof_one;
  logic [7:0]      sof_two;
  logic [7:0]      want_version;
  logic [FC_W-1:0] max_len_cfg;
  logic [15:0]     timeout_cfg;

  // parser copy
  fpr_phase_t      rx_phase;
  logic [7:0]      rx_version;
  logic [7:0]      rx_type;
  logic [7:0]      rx_seq;
  logic [7:0]      rx_len;
  logic [FC_W-1:0] rx_count;
  logic [7:0]      rx_crc_low;
  logic [15:0]     rx_crc;
  logic [7:0]      rx_payload [MAX_PAYLOAD];
  logic [15:0]     rx_idle;

  link_item_t    link_items [$];
  frame_result_t results_due [$];
  link_item_t    staged;
  frame_result_t want;

  int burst_left;
  int gap_left;
  int stall_cycle;
  int stall_style;
  int quiet_cycles;
  int mismatches;
  int pushed_total;

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    return c;
  endfunction

  function automatic int payload_limit();
    return (max_len_cfg < MAX_PAYLOAD) ? int'(max_len_cfg) : int'(MAX_PAYLOAD);
  endfunction

  task automatic start_hunt();
    rx_phase   = PH_SOF1;
    rx_version = 8'h00;
    rx_type    = 8'h00;
    rx_seq     = 8'h00;
    rx_len     = 8'h00;
    rx_count   = '0;
    rx_crc_low = 8'h00;
    rx_crc     = CRC_INIT;
    rx_idle    = 16'h0000;
  endtask

  task automatic emit_result(input fpr_status_t st, input logic [15:0] detail,
                             input logic [7:0] pb, input logic [PAY_AW-1:0] idx,
                             input logic has, input logic last_flag);
    frame_result_t r;
    r.status       = st;
    r.frame_type   = rx_type;
    r.frame_seq    = rx_seq;
    r.frame_len    = rx_len;
    r.detail       = detail;
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.has_payload  = has;
    r.last         = last_flag;
    results_due.push_back(r);
  endtask

  task automatic track_link_item(input logic mode, input logic [7:0] b);
    logic [15:0]       received;
    logic [PAY_AW-1:0] idx_v;
    if (mode == MODE_TICK) begin
      if (rx_phase == PH_SOF1) return;
      if (rx_idle != 16'hFFFF) rx_idle = rx_idle + 16'd1;
      if (rx_idle >= timeout_cfg) begin
        emit_result(ST_TIMEOUT, 16'h0000, 8'h00, '0, 1'b0, 1'b1);
        start_hunt();
      end
      return;
    end
    rx_idle = 16'h0000;
    case (rx_phase)
      PH_SOF1: begin
        if (b == sof_one) begin
          rx_phase   = PH_SOF2;
          rx_version = 8'h00;
          rx_type    = 8'h00;
          rx_seq     = 8'h00;
          rx_len     = 8'h00;
          rx_count   = '0;
        end
      end
      PH_SOF2: begin
        if (b == sof_two) begin
          rx_phase   = PH_HDR;
          rx_version = 8'h00;
          rx_type    = 8'h00;
          rx_seq     = 8'h00;
          rx_len     = 8'h00;
          rx_count   = '0;
          rx_crc     = CRC_INIT;
        end else if (b != sof_one) begin
          start_hunt();
        end
      end
      PH_HDR: begin
        rx_crc = modbus_crc_byte(rx_crc, b);
        case (rx_count)
          0: rx_version = b;
          1: rx_type = b;
          2: rx_seq = b;
          default: rx_len = b;
        endcase
        rx_count = rx_count + 1'b1;
        if (rx_count >= HDR_BYTES) begin
          if (rx_len > payload_limit()) begin
            emit_result(ST_LEN, {8'h00, rx_len}, 8'h00, '0, 1'b0, 1'b1);
            start_hunt();
          end else begin
            rx_count = '0;
            rx_phase = (rx_len == 8'h00) ? PH_CRCL : PH_PAY;
          end
        end
      end
      PH_PAY: begin
        rx_crc = modbus_crc_byte(rx_crc, b);
        if (rx_count < MAX_PAYLOAD) rx_payload[rx_count] = b;
        rx_count = rx_count + 1'b1;
        if (rx_count >= rx_len) rx_phase = PH_CRCL;
      end
      PH_CRCL: begin
        rx_crc_low = b;
        rx_phase   = PH_CRCH;
      end
      default: begin
        received = {b, rx_crc_low};
        if (received != rx_crc) begin
          emit_result(ST_CRC, received, 8'h00, '0, 1'b0, 1'b1);
        end else if (rx_version != want_version) begin
          emit_result(ST_VER, {8'h00, rx_version}, 8'h00, '0, 1'b0, 1'b1);
        end else if (rx_len == 8'h00) begin
          emit_result(ST_OK, 16'h0000, 8'h00, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < rx_len && i < MAX_PAYLOAD; i++) begin
            idx_v = PAY_AW'(i);
            emit_result(ST_OK, 16'h0000, rx_payload[i], idx_v, 1'b1, (i + 1 == rx_len));
          end
        end
        start_hunt();
      end
    endcase
  endtask

  task automatic push_item(input logic mode, input logic [7:0] b);
    link_item_t it;
    it.mode      = mode;
    it.data_byte = b;
    link_items.push_back(it);
    pushed_total++;
  endtask

  task automatic wait_drained();
    while (link_items.size() != 0 || in_ch.valid || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic return_to_hunt();
    logic [7:0] filler;
    wait_drained();
    while (rx_phase != PH_SOF1) begin
      filler = 8'h00;
      if (rx_phase == PH_SOF2) begin
        while (filler == sof_one || filler == sof_two) filler = filler + 8'd1;
      end
      push_item(MODE_BYTE, filler);
      wait_drained();
    end
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SOF_ONE: sof_one = value[7:0];
      CFG_SOF_TWO: sof_two = value[7:0];
      CFG_VERSION: want_version = value[7:0];
      CFG_MAX_LEN: max_len_cfg = value[FC_W-1:0];
      CFG_TIMEOUT: timeout_cfg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] kind,
                             input logic [7:0] seq, input logic [7:0] len_byte,
                             input bit bad_crc, input int cut_at, input int pause_at);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    crc = CRC_INIT;
    frame_bytes.push_back(sof_one);
    frame_bytes.push_back(sof_two);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(kind);
    frame_bytes.push_back(seq);
    frame_bytes.push_back(len_byte);
    for (int i = 2; i < 6; i++) crc = modbus_crc_byte(crc, frame_bytes[i]);
    if (len_byte <= payload_limit()) begin
      for (int i = 0; i < len_byte; i++) begin
        frame_bytes.push_back($urandom_range(0, 255));
        crc = modbus_crc_byte(crc, frame_bytes[frame_bytes.size() - 1]);
      end
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
    end
    foreach (frame_bytes[i]) begin
      if (i == cut_at) break;
      if (i == pause_at) wait_drained();
      if (timeout_cfg > 4 && $urandom_range(0, 19) == 0)
        push_item(MODE_TICK, $urandom_range(0, 255));
      push_item(MODE_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic queue_random_traffic(input int budget);
    int         stop_at;
    int         lim;
    int         pick;
    int         cut_at;
    int         pause_at;
    int         r;
    bit         paused;
    logic [7:0] len_byte;
    logic [7:0] ver;
    stop_at = pushed_total + budget;
    paused  = 1'b0;
    while (pushed_total < stop_at) begin
      pick = $urandom_range(0, 99);
      lim  = payload_limit();
      if (pick < 12) begin
        repeat ($urandom_range(1, 6)) begin
          push_item(MODE_BYTE, ($urandom_range(0, 3) == 0) ? sof_one : $urandom_range(0, 255));
        end
      end else if (pick < 22) begin
        repeat ($urandom_range(1, 4)) push_item(MODE_TICK, $urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) len_byte = $urandom_range(0, (lim < 6) ? lim : 6);
        else if (r < 8) len_byte = $urandom_range(0, lim);
        else len_byte = $urandom_range(lim + 1, 255);
        ver      = ($urandom_range(0, 4) != 0) ? want_version : $urandom_range(0, 255);
        cut_at   = (pick >= 80 && pick < 90) ? $urandom_range(1, 7) : -1;
        pause_at = -1;
        if (!paused && cut_at < 0) begin
          pause_at = $urandom_range(3, 6);
          paused   = 1'b1;
        end
        if (pick >= 90) repeat ($urandom_range(1, 3)) push_item(MODE_BYTE, sof_one);
        queue_frame(ver, $urandom_range(0, 255), $urandom_range(0, 255), len_byte,
                    ($urandom_range(0, 6) == 0), cut_at, pause_at);
        if (cut_at >= 0 && timeout_cfg <= 64) begin
          repeat (timeout_cfg) push_item(MODE_TICK, $urandom_range(0, 255));
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.mode      <= MODE_BYTE;
      in_ch.data_byte <= 8'h00;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_link_item(in_ch.mode, in_ch.data_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (link_items.size() != 0) begin
          staged = link_items.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.mode      <= staged.mode;
          in_ch.data_byte <= staged.data_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cycle = 0;
      stall_style = 0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 64 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (stall_cycle % 8 == 0);
        default: out_ch.ready <= (stall_cycle % 32 >= 12);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got status %0d detail %h payload %h last %b",
                 $time, out_ch.status, out_ch.detail, out_ch.payload_byte, out_ch.last);
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("frame_type", want.frame_type, out_ch.frame_type);
        check_field("frame_seq", want.frame_seq, out_ch.frame_seq);
        check_field("frame_len", want.frame_len, out_ch.frame_len);
        check_field("detail", want.detail, out_ch.detail);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("byte_index", want.byte_index, out_ch.byte_index);
        check_field("has_payload", want.has_payload, out_ch.has_payload);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("framed_packet_receiver_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sof_one         = SOF_ONE_RST;
    sof_two         = SOF_TWO_RST;
    want_version    = VERSION_RST;
    max_len_cfg     = MAX_LEN_RST;
    timeout_cfg     = TIMEOUT_RST;
    start_hunt();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: tick while hunting, empty frame, repeated start, crc before version, over-long length
    push_item(MODE_TICK, 8'hFF);
    queue_frame(VERSION_RST, 8'h00, 8'hFF, 8'h00, 1'b0, -1, -1);
    push_item(MODE_BYTE, sof_one);
    queue_frame(8'h07, 8'hFF, 8'h00, 8'h00, 1'b1, -1, -1);
    queue_frame(VERSION_RST, 8'h5C, 8'hA3, 8'd65, 1'b0, -1, -1);
    queue_random_traffic(96);
    return_to_hunt();

    // low extremes: zero length limit, one-tick timeout
    write_reg(CFG_SOF_ONE, 16'h0000);
    write_reg(CFG_SOF_TWO, 16'h00FF);
    write_reg(CFG_VERSION, 16'h0000);
    write_reg(CFG_MAX_LEN, 16'h0000);
    write_reg(CFG_TIMEOUT, 16'h0001);
    push_item(MODE_BYTE, sof_one);
    push_item(MODE_TICK, 8'h00);
    queue_frame(8'h00, 8'hAB, 8'h00, 8'h00, 1'b0, 4, -1);
    push_item(MODE_TICK, 8'hFF);
    queue_frame(8'h00, 8'h81, 8'h7E, 8'h00, 1'b0, -1, -1);
    queue_frame(8'h00, 8'h42, 8'h24, 8'h01, 1'b0, -1, -1);
    queue_random_traffic(96);
    return_to_hunt();

    // equal start bytes, upper bits masked off, longest timeout, unused indexes
    write_reg(CFG_SOF_ONE, 16'hFF7E);
    write_reg(CFG_SOF_TWO, 16'h007E);
    write_reg(CFG_VERSION, 16'hFFFF);
    write_reg(CFG_MAX_LEN, 16'hFFC0);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_UNUSED_LO, 16'h1234);
    write_reg(CFG_UNUSED_HI, 16'hFFFF);
    push_item(MODE_BYTE, sof_one);
    repeat (8) push_item(MODE_TICK, $urandom_range(0, 255));
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'd64, 1'b0, -1, -1);
    queue_random_traffic(96);
    return_to_hunt();

    write_reg(CFG_SOF_ONE, $urandom_range(0, 255));
    write_reg(CFG_SOF_TWO, $urandom_range(0, 255));
    write_reg(CFG_VERSION, $urandom_range(0, 255));
    write_reg(CFG_MAX_LEN, $urandom_range(0, 64));
    write_reg(CFG_TIMEOUT, $urandom_range(1, 40));
    queue_random_traffic(96);
    return_to_hunt();

    write_reg(CFG_SOF_ONE, 16'h00C3);
    write_reg(CFG_SOF_TWO, 16'h003C);
    write_reg(CFG_VERSION, 16'h0080);
    write_reg(CFG_MAX_LEN, 16'h0005);
    write_reg(CFG_TIMEOUT, 16'h0003);
    queue_random_traffic(96);
    return_to_hunt();

    repeat (32) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("framed_packet_receiver_top: match");
    end else begin
      $display("framed_packet_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
